// ===== hw/rtl/sparse_row_matvec_accumulator_top_defines.svh =====
// Assertion macros for the sparse row accumulator.
// Each expects clk and arst_n in the scope of use.
`ifndef SPARSE_ROW_MATVEC_ACCUMULATOR_TOP_DEFINES_SVH
`define SPARSE_ROW_MATVEC_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset
`define SRMA_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sparse row accumulator check failed");

// Next-cycle implication, held off during reset
`define SRMA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sparse row accumulator check failed");

`endif

// ===== hw/rtl/srma_pkg.sv =====
package srma_pkg;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_NONZERO = 2'd1,
		OP_ROW_END = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

	// Output queue: sized to cover the pipeline so a full rate stream stalls only under output back-pressure
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	typedef struct packed {
		logic [63:0] sum;
		logic        clip;
	} sat_t;

	typedef struct packed {
		logic [15:0] row_number;
		logic [63:0] row_result;
		logic        saturated;
	} out_entry_t;

	// Saturating signed 64-bit addition on two's-complement patterns
	function automatic sat_t sat_add(input logic [63:0] a, input logic [63:0] b);
		sat_t        r;
		logic [63:0] s;
		s      = a + b;
		r.clip = (a[63] == b[63]) && (s[63] != a[63]);
		r.sum  = r.clip ? (a[63] ? SAT_MIN : SAT_MAX) : s;
		return r;
	endfunction

endpackage

// ===== hw/rtl/sparse_row_matvec_accumulator_top.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_stall    op, column_index, value, last_in_row, row_initial
// output    out_valid / out_stall  row_number, row_result, saturated
// config    cfg_write_en           cfg_write_data (row_count)
//
// One item is taken every cycle while in_stall is low. A result passes the stage 1,
// stage 2 and stage 3 registers into the output queue. Path: vector store read,
// 32x32 multiply, row sum accumulate, add initial value. Results wait in an eight-entry
// output queue; input stalls only while eight results are queued or in flight. Reset
// clears row sum, counter and queue; the vector store is not cleared.
module sparse_row_matvec_accumulator_top import srma_pkg::*; #(
	parameter int MAX_COLUMNS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [11:0]        column_index,
	input  logic signed [31:0] value,
	input  logic               last_in_row,
	input  logic signed [63:0] row_initial,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        row_number,
	output logic signed [63:0] row_result,
	output logic               saturated,
	input  logic               cfg_write_en,
	input  logic [15:0]        cfg_write_data
);

	`include "sparse_row_matvec_accumulator_top_defines.svh"

	localparam int ADDR_W = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
	localparam int COL_W  = (ADDR_W > 12) ? ADDR_W : 12;

	// Configuration register
	logic [15:0] row_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 16'd1;
		end else if (cfg_write_en) begin
			row_count_q <= cfg_write_data;
		end
	end

	// Decode the incoming transaction
	logic              fire;
	logic              load_we;
	logic              mac_in;
	logic              finish_in;
	logic [COL_W-1:0]  col_ext;
	logic              in_range;
	logic [ADDR_W-1:0] addr;

	assign fire     = in_valid && !in_stall;
	assign col_ext  = COL_W'(column_index);
	assign in_range = {1'b0, col_ext} < (COL_W + 1)'(MAX_COLUMNS);
	assign addr     = col_ext[ADDR_W-1:0];

	always_comb begin
		load_we   = 1'b0;
		mac_in    = 1'b0;
		finish_in = 1'b0;
		case (op_t'(op))
			OP_LOAD: begin
				load_we = in_range;
			end
			OP_NONZERO: begin
				mac_in    = 1'b1;
				finish_in = last_in_row;
			end
			OP_ROW_END: begin
				finish_in = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Vector store: an in-range load writes it; every accepted transaction reads it
	logic [31:0] vec_mem [MAX_COLUMNS];
	logic [31:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (fire && load_we) begin
			vec_mem[addr] <= value;
		end
		if (fire) begin
			rd_data_s1 <= vec_mem[addr];
		end
	end

	// Stage 1: carry the item alongside the store read
	logic               valid_s1, finish_s1, mac_s1, range_s1;
	logic signed [31:0] value_s1;
	logic [63:0]        initial_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire && (mac_in || finish_in);
		end
	end

	always_ff @(posedge clk) begin
		finish_s1  <= finish_in;
		mac_s1     <= mac_in;
		range_s1   <= in_range;
		value_s1   <= value;
		initial_s1 <= row_initial;
	end

	// Stage 2: multiply; out of range or row end contributes zero
	logic signed [31:0] vec_x;
	logic signed [63:0] prod;
	logic               valid_s2, finish_s2;
	logic [63:0]        prod_s2, initial_s2;

	assign vec_x = (mac_s1 && range_s1) ? $signed(rd_data_s1) : 32'sd0;
	assign prod  = 64'(value_s1) * 64'(vec_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		finish_s2  <= finish_s1;
		prod_s2    <= prod;
		initial_s2 <= initial_s1;
	end

	// Stage 3: accumulate into the row sum, close the row on finish
	logic [63:0] row_sum_q;
	logic        clip_q;
	logic [15:0] row_counter_q;
	sat_t        acc;
	logic [16:0] next_row;
	logic        valid_s3;
	logic [63:0] sum_s3, initial_s3;
	logic        clip_s3;
	logic [15:0] row_s3;

	assign acc      = sat_add(row_sum_q, prod_s2);
	assign next_row = {1'b0, row_counter_q} + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q     <= '0;
			clip_q        <= 1'b0;
			row_counter_q <= '0;
			valid_s3      <= 1'b0;
		end else begin
			valid_s3 <= valid_s2 && finish_s2;
			if (valid_s2) begin
				if (finish_s2) begin
					row_sum_q     <= '0;
					clip_q        <= 1'b0;
					row_counter_q <= (next_row >= {1'b0, row_count_q}) ? 16'd0 : next_row[15:0];
				end else begin
					row_sum_q <= acc.sum;
					clip_q    <= clip_q || acc.clip;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_s3     <= acc.sum;
		clip_s3    <= clip_q || acc.clip;
		initial_s3 <= initial_s2;
		row_s3     <= row_counter_q;
	end

	// Final addition of the initial value, into the output queue
	sat_t       fin;
	out_entry_t new_entry;

	assign fin                  = sat_add(initial_s3, sum_s3);
	assign new_entry.row_number = row_s3;
	assign new_entry.row_result = fin.sum;
	assign new_entry.saturated  = clip_s3 || fin.clip;

	out_entry_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] fifo_cnt_q, credits_q;
	logic                  pop, reserve;

	assign out_valid  = (fifo_cnt_q != '0);
	assign pop        = out_valid && !out_stall;
	assign reserve    = fire && finish_in;
	assign in_stall   = (credits_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign row_number = fifo_q[rd_ptr_q].row_number;
	assign row_result = fifo_q[rd_ptr_q].row_result;
	assign saturated  = fifo_q[rd_ptr_q].saturated;

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end

	// Advance pointers; reserve a slot per finishing transaction at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			credits_q  <= '0;
		end else begin
			if (valid_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({valid_s3, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 1'b1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 1'b1;
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
			case ({reserve, pop})
				2'b10:   credits_q <= credits_q + 1'b1;
				2'b01:   credits_q <= credits_q - 1'b1;
				default: credits_q <= credits_q;
			endcase
		end
	end

	// Checks
	`SRMA_ASSERT_NOW(a_credit_bound, 1'b1, credits_q <= FIFO_CNT_W'(FIFO_DEPTH))
	`SRMA_ASSERT_NOW(a_queue_within_credit, 1'b1, fifo_cnt_q <= credits_q)
	`SRMA_ASSERT_NEXT(a_row_close_clears, valid_s2 && finish_s2, row_sum_q == '0 && !clip_q)
	`SRMA_ASSERT_NOW(a_write_has_room, valid_s3, fifo_cnt_q < FIFO_CNT_W'(FIFO_DEPTH) || pop)

endmodule
